>>> rtl/box_blur_3x3_rgb_unit_assert.svh
// Assertion helpers shared by the blur unit RTL.
// All of them sample on clk and are disabled while arst_n is low.
`ifndef BOX_BLUR_3X3_RGB_UNIT_ASSERT_SVH
`define BOX_BLUR_3X3_RGB_UNIT_ASSERT_SVH

// Condition that must hold at every clock edge
`define BB_ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Trigger in one cycle implies a condition in the next cycle
`define BB_ASSERT_NEXT(lbl, trig, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cond)) else $error(msg);

`endif

>>> rtl/bblur_pkg.sv
package bblur_pkg;

	// Parameter defaults
	localparam int MAX_WIDTH_DEF  = 2048;
	localparam int MAX_HEIGHT_DEF = 2048;

	// Register reset values
	localparam int FRAME_WIDTH_RST  = 640;
	localparam int FRAME_HEIGHT_RST = 480;

	// Field widths
	localparam int CFG_W = 12;
	localparam int PIX_W = 8;
	localparam int POS_W = 11;

	// Result queue: up to three results per pixel
	localparam int MAX_RES   = 3;
	localparam int RES_NW    = $clog2(MAX_RES + 1);
	localparam int RES_DEPTH = 8;

	// floor(s / 9) for s <= 2295 as (s * 3641) >> 15
	localparam int SUM_W      = 12;
	localparam int DIV9_MUL   = 3641;
	localparam int DIV9_SHIFT = 15;
	localparam int DIV9_PW    = 24;

	typedef enum logic [0:0] {
		CFG_FRAME_WIDTH  = 1'b0,
		CFG_FRAME_HEIGHT = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		logic [PIX_W-1:0] red_in;
		logic [PIX_W-1:0] green_in;
		logic [PIX_W-1:0] blue_in;
	} pix_in_t;

	typedef struct packed {
		logic [PIX_W-1:0] red_out;
		logic [PIX_W-1:0] green_out;
		logic [PIX_W-1:0] blue_out;
		logic [POS_W-1:0] out_row;
		logic [POS_W-1:0] out_col;
		logic             run_last;
	} pix_out_t;

	// Results of one pixel, in emission order, n of them valid
	typedef struct packed {
		logic [RES_NW-1:0]           n;
		pix_out_t [MAX_RES-1:0]      item;
	} res_push_t;

	function automatic logic [PIX_W-1:0] div9(input logic [SUM_W-1:0] s);
		logic [DIV9_PW-1:0] prod;
		prod = DIV9_PW'(s) * DIV9_PW'(DIV9_MUL);
		return prod[DIV9_SHIFT +: PIX_W];
	endfunction

endpackage

>>> rtl/bblur_line_ram.sv
// Simple dual-port line store: one write, one registered read
module bblur_line_ram import bblur_pkg::*; #(
	parameter int DEPTH = MAX_WIDTH_DEF,
	parameter int WIDTH = 3 * PIX_W
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read port, data held while not reading
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> rtl/bblur_res_fifo.sv
`include "box_blur_3x3_rgb_unit_assert.svh"

// Result queue: takes up to three results in one cycle, hands out one per cycle while res_stall is low
module bblur_res_fifo import bblur_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  res_push_t push,
	output logic      space_ok,
	output logic      res_valid,
	input  logic      res_stall,
	output pix_out_t  res
);

	localparam int PW = $clog2(RES_DEPTH);
	localparam int CW = PW + 1;

	pix_out_t        mem [RES_DEPTH];
	logic [PW-1:0]   wptr_q;
	logic [PW-1:0]   rptr_q;
	logic [CW-1:0]   cnt_q;
	logic            pop;

	assign pop       = res_valid && !res_stall;
	assign res_valid = (cnt_q != '0);
	assign res       = mem[rptr_q];
	// room for a full group of results
	assign space_ok  = (cnt_q <= CW'(RES_DEPTH - MAX_RES));

	// entry storage
	always_ff @(posedge clk) begin
		for (int i = 0; i < MAX_RES; i++) begin
			if (RES_NW'(i) < push.n) begin
				mem[wptr_q + PW'(i)] <= push.item[i];
			end
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			wptr_q <= wptr_q + PW'(push.n);
			if (pop) begin
				rptr_q <= rptr_q + PW'(1);
			end
			cnt_q <= cnt_q + CW'(push.n) - CW'(pop);
		end
	end

	`BB_ASSERT_ALWAYS(a_fifo_bound, cnt_q <= CW'(RES_DEPTH), "result queue overflow")
	`BB_ASSERT_ALWAYS(a_fifo_room, (push.n == '0) || space_ok, "push without room")
	`BB_ASSERT_NEXT(a_fifo_drain, pop && (push.n == '0), cnt_q == $past(cnt_q) - CW'(1), "pop lost")

endmodule

>>> rtl/box_blur_3x3_rgb_unit.sv
// The first result of a pixel enters the result queue when the pixel leaves stage 1.
// Throughput: one pixel per cycle; after the first row, row ends give two results and the last
// row one to three per pixel, the extra results drained from an 8-entry result queue at one per
// cycle while res_stall is low; input stalls while stage 1 is full and over five results wait.
// Line stores are read at the pixel's transfer and written when it leaves stage 1.
// Reset (arst_n low, asynchronous): counters, window and queue clear, sizes return to 640x480;
// line store contents are not cleared.
`include "box_blur_3x3_rgb_unit_assert.svh"

module box_blur_3x3_rgb_unit import bblur_pkg::*; #(
	parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             pix_valid,
	output logic             pix_stall,
	input  pix_in_t          pix,
	output logic             res_valid,
	input  logic             res_stall,
	output pix_out_t         res,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  cfg_reg_t         cfg_index,
	input  logic [CFG_W-1:0] cfg_data
);

	localparam int AW  = $clog2(MAX_WIDTH);
	localparam int CLW = (CFG_W > $clog2(MAX_WIDTH + 1)) ? CFG_W : $clog2(MAX_WIDTH + 1);
	localparam int RLW = (CFG_W > $clog2(MAX_HEIGHT + 1)) ? CFG_W : $clog2(MAX_HEIGHT + 1);
	localparam int COL_LAST_RST =
		((FRAME_WIDTH_RST > MAX_WIDTH) ? MAX_WIDTH : FRAME_WIDTH_RST) - 1;
	localparam int ROW_LAST_RST =
		((FRAME_HEIGHT_RST > MAX_HEIGHT) ? MAX_HEIGHT : FRAME_HEIGHT_RST) - 1;
	localparam int CS_W = PIX_W + 2;

	typedef struct packed {
		logic [PIX_W-1:0] r;
		logic [PIX_W-1:0] g;
		logic [PIX_W-1:0] b;
	} rgb_t;

	typedef struct packed {
		logic [CS_W-1:0] r;
		logic [CS_W-1:0] g;
		logic [CS_W-1:0] b;
	} csum_t;

	// what a pixel emits, decided at transfer
	typedef struct packed {
		logic diag;
		logic tail;
		logic last;
		logic border;
	} emit_t;

	// configuration, stored as last index
	logic [CLW-1:0] col_last_q;
	logic [RLW-1:0] row_last_q;
	logic [CLW-1:0] cfg_col_last;
	logic [RLW-1:0] cfg_row_last;
	logic           cfg_we;

	// position counters
	logic [POS_W-1:0] col_q;
	logic [POS_W-1:0] row_q;
	logic             row_end;
	logic             last_row;
	emit_t            emit;

	// stage 1
	logic             s1_valid_q;
	rgb_t             pix_s1;
	logic [POS_W-1:0] row_s1;
	logic [POS_W-1:0] col_s1;
	emit_t            emit_s1;
	logic [AW-1:0]    addr_s1;
	logic             byp_s1;
	rgb_t             byp_up_s1;
	rgb_t             byp_mid_s1;
	rgb_t             up_rd_s1;
	rgb_t             mid_rd_s1;
	rgb_t             up_eff;
	rgb_t             mid_eff;

	// window
	csum_t            cs1_q;
	csum_t            cs2_q;
	rgb_t             wmid_q;
	csum_t            cs_now;

	// handshake
	logic             pix_accept;
	logic             s1_fire;
	logic             space_ok;
	logic [AW-1:0]    rd_addr;

	// results
	logic [SUM_W-1:0] sum_r;
	logic [SUM_W-1:0] sum_g;
	logic [SUM_W-1:0] sum_b;
	pix_out_t         diag_item;
	pix_out_t         tail_item;
	pix_out_t         last_item;
	logic [RES_NW-1:0] k;
	res_push_t        push;

	// ---------------- configuration ----------------
	assign cfg_ready = 1'b1;
	assign cfg_we    = cfg_valid && cfg_ready;

	// zero acts as one, oversize clamps to the maximum
	assign cfg_col_last = (cfg_data == '0) ? '0 :
		(CLW'(cfg_data) > CLW'(MAX_WIDTH)) ? CLW'(MAX_WIDTH - 1) : CLW'(cfg_data) - CLW'(1);
	assign cfg_row_last = (cfg_data == '0) ? '0 :
		(RLW'(cfg_data) > RLW'(MAX_HEIGHT)) ? RLW'(MAX_HEIGHT - 1) : RLW'(cfg_data) - RLW'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_last_q <= CLW'(COL_LAST_RST);
			row_last_q <= RLW'(ROW_LAST_RST);
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_FRAME_WIDTH:  col_last_q <= cfg_col_last;
				CFG_FRAME_HEIGHT: row_last_q <= cfg_row_last;
				default: ;
			endcase
		end
	end

	// ---------------- handshake ----------------
	assign s1_fire    = s1_valid_q && space_ok;
	assign pix_stall  = s1_valid_q && !s1_fire;
	assign pix_accept = pix_valid && !pix_stall;
	assign rd_addr    = AW'(col_q);

	// ---------------- emission decision at transfer ----------------
	assign row_end  = CLW'(col_q) >= col_last_q;
	assign last_row = RLW'(row_q) >= row_last_q;

	always_comb begin
		emit.diag   = (row_q != '0) && (col_q != '0);
		emit.tail   = (row_q != '0) && row_end;
		emit.last   = last_row;
		// border test for pixel (row-1, col-1)
		emit.border = (row_q == POS_W'(1)) || (col_q == POS_W'(1)) ||
			(RLW'(row_q - POS_W'(1)) >= row_last_q) ||
			(CLW'(col_q - POS_W'(1)) >= col_last_q);
	end

	// counters wrap at row end and frame end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (pix_accept) begin
			if (row_end) begin
				col_q <= '0;
				row_q <= last_row ? '0 : row_q + POS_W'(1);
			end else begin
				col_q <= col_q + POS_W'(1);
			end
		end
	end

	// ---------------- line stores ----------------
	bblur_line_ram #(
		.DEPTH (MAX_WIDTH),
		.WIDTH ($bits(rgb_t))
	) u_upper_ram (
		.clk   (clk),
		.we    (s1_fire),
		.waddr (addr_s1),
		.wdata (mid_eff),
		.re    (pix_accept),
		.raddr (rd_addr),
		.rdata (up_rd_s1)
	);

	bblur_line_ram #(
		.DEPTH (MAX_WIDTH),
		.WIDTH ($bits(rgb_t))
	) u_middle_ram (
		.clk   (clk),
		.we    (s1_fire),
		.waddr (addr_s1),
		.wdata (pix_s1),
		.re    (pix_accept),
		.raddr (rd_addr),
		.rdata (mid_rd_s1)
	);

	// a read of the column being written in the same cycle takes the new data
	assign up_eff  = byp_s1 ? byp_up_s1  : up_rd_s1;
	assign mid_eff = byp_s1 ? byp_mid_s1 : mid_rd_s1;

	// ---------------- stage 1 ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (pix_accept) begin
			s1_valid_q <= 1'b1;
		end else if (s1_fire) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pix_accept) begin
			pix_s1     <= rgb_t'(pix);
			row_s1     <= row_q;
			col_s1     <= col_q;
			emit_s1    <= emit;
			addr_s1    <= rd_addr;
			byp_s1     <= s1_fire && (addr_s1 == rd_addr);
			byp_up_s1  <= mid_eff;
			byp_mid_s1 <= pix_s1;
		end
	end

	// ---------------- window of column sums ----------------
	always_comb begin
		cs_now.r = CS_W'(up_eff.r) + CS_W'(mid_eff.r) + CS_W'(pix_s1.r);
		cs_now.g = CS_W'(up_eff.g) + CS_W'(mid_eff.g) + CS_W'(pix_s1.g);
		cs_now.b = CS_W'(up_eff.b) + CS_W'(mid_eff.b) + CS_W'(pix_s1.b);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cs1_q  <= '0;
			cs2_q  <= '0;
			wmid_q <= '0;
		end else if (s1_fire) begin
			cs2_q  <= cs1_q;
			cs1_q  <= cs_now;
			wmid_q <= mid_eff;
		end
	end

	// ---------------- results ----------------
	assign sum_r = SUM_W'(cs2_q.r) + SUM_W'(cs1_q.r) + SUM_W'(cs_now.r);
	assign sum_g = SUM_W'(cs2_q.g) + SUM_W'(cs1_q.g) + SUM_W'(cs_now.g);
	assign sum_b = SUM_W'(cs2_q.b) + SUM_W'(cs1_q.b) + SUM_W'(cs_now.b);

	always_comb begin
		// neighbor (row-1, col-1): mean of nine or passed through on the border
		diag_item.red_out   = emit_s1.border ? wmid_q.r : div9(sum_r);
		diag_item.green_out = emit_s1.border ? wmid_q.g : div9(sum_g);
		diag_item.blue_out  = emit_s1.border ? wmid_q.b : div9(sum_b);
		diag_item.out_row   = row_s1 - POS_W'(1);
		diag_item.out_col   = col_s1 - POS_W'(1);
		diag_item.run_last  = !(emit_s1.tail || emit_s1.last);

		// last column of the previous row
		tail_item.red_out   = mid_eff.r;
		tail_item.green_out = mid_eff.g;
		tail_item.blue_out  = mid_eff.b;
		tail_item.out_row   = row_s1 - POS_W'(1);
		tail_item.out_col   = col_s1;
		tail_item.run_last  = !emit_s1.last;

		// last row passes through
		last_item.red_out   = pix_s1.r;
		last_item.green_out = pix_s1.g;
		last_item.blue_out  = pix_s1.b;
		last_item.out_row   = row_s1;
		last_item.out_col   = col_s1;
		last_item.run_last  = 1'b1;
	end

	// pack present results in order
	always_comb begin
		k         = '0;
		push.item = '0;
		if (emit_s1.diag) begin
			push.item[k] = diag_item;
			k = k + RES_NW'(1);
		end
		if (emit_s1.tail) begin
			push.item[k] = tail_item;
			k = k + RES_NW'(1);
		end
		if (emit_s1.last) begin
			push.item[k] = last_item;
			k = k + RES_NW'(1);
		end
		push.n = s1_fire ? k : '0;
	end

	bblur_res_fifo u_res_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.space_ok  (space_ok),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);

	`BB_ASSERT_NEXT(a_s1_loaded, pix_accept, s1_valid_q, "transfer did not load stage 1")
	`BB_ASSERT_NEXT(a_col_step, pix_accept, (col_q == '0) || (col_q == $past(col_q) + POS_W'(1)), "column counter skipped")
	`BB_ASSERT_ALWAYS(a_addr_range, !pix_accept || (32'(col_q) < MAX_WIDTH), "line store address out of range")

endmodule
